[rtl/core/perbg_pkg.sv]
// Package for the periodic Burgers 3D stencil block.
// Shared types, constants and saturation helpers; no dependencies.
package perbg_pkg;

   localparam int DATA_W        = 32;
   localparam int POS_W         = 5;
   localparam int POS_VALUES    = 2 ** POS_W;
   localparam int WIDE_W        = 48;
   localparam int MUL_B_W       = 33;
   localparam int SUM_W         = 50;
   localparam int NSUM_W        = 35;
   localparam int MUL_LAT       = 4;
   localparam int DIM_X_DEF     = 32;
   localparam int DIM_Y_DEF     = 32;
   localparam int DIM_Z_DEF     = 32;
   localparam int QUEUE_DEPTH_DEF = 4;
   localparam int CSR_INDEX_W   = 3;

   localparam logic signed [SUM_W-1:0] W48_HI = 50'sh0_7FFF_FFFF_FFFF;
   localparam logic signed [SUM_W-1:0] W48_LO = 50'sh3_8000_0000_0000;
   localparam logic signed [48:0]      W32_HI = 49'sh0_0000_7FFF_FFFF;
   localparam logic signed [48:0]      W32_LO = 49'sh1_FFFF_8000_0000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ADVECT = 3'd0,
      CSR_FIRST  = 3'd1,
      CSR_CENTER = 3'd2,
      CSR_DIFFUSE = 3'd3,
      CSR_STEP   = 3'd4
   } csr_index_type;

   typedef enum logic {
      KIND_LOAD   = 1'b0,
      KIND_UPDATE = 1'b1
   } req_kind_type;

   // neighbor read order
   typedef enum logic [2:0] {
      NB_XM = 3'd0,
      NB_XP = 3'd1,
      NB_YM = 3'd2,
      NB_YP = 3'd3,
      NB_ZM = 3'd4,
      NB_ZP = 3'd5
   } nb_slot_type;

   typedef struct packed {
      logic [DATA_W-1:0] advect;
      logic [DATA_W-1:0] first;
      logic [DATA_W-1:0] center;
      logic [DATA_W-1:0] diffuse;
      logic [DATA_W-1:0] step;
   } coef_type;

   // side data that travels beside the multiplier pipes
   typedef struct packed {
      logic              valid;
      logic [POS_W-1:0]  x;
      logic [POS_W-1:0]  y;
      logic [POS_W-1:0]  z;
      logic [DATA_W-1:0] u;
      logic [NSUM_W-1:0] nsum;
      logic [WIDE_W-1:0] cterm;
      logic              sat;
   } carry_type;

   typedef struct packed {
      logic              sat;
      logic [WIDE_W-1:0] val;
   } clamp48_type;

   typedef struct packed {
      logic              sat;
      logic [DATA_W-1:0] val;
   } clamp32_type;

   // queued item: {kind, x, y, z, value, vel_x, vel_y, vel_z}
   function automatic int item_w(input int dx, input int dy, input int dz);
      return 1 + $clog2(dx) + $clog2(dy) + $clog2(dz) + 4 * DATA_W;
   endfunction

   function automatic clamp48_type clamp48(input logic signed [SUM_W-1:0] v);
      clamp48_type r;
      r.sat = (v > W48_HI) || (v < W48_LO);
      if (v > W48_HI) begin
         r.val = W48_HI[WIDE_W-1:0];
      end else if (v < W48_LO) begin
         r.val = W48_LO[WIDE_W-1:0];
      end else begin
         r.val = v[WIDE_W-1:0];
      end
      return r;
   endfunction

   function automatic clamp32_type clamp32(input logic signed [48:0] v);
      clamp32_type r;
      r.sat = (v > W32_HI) || (v < W32_LO);
      if (v > W32_HI) begin
         r.val = W32_HI[DATA_W-1:0];
      end else if (v < W32_LO) begin
         r.val = W32_LO[DATA_W-1:0];
      end else begin
         r.val = v[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

[rtl/core/perbg_mulq.sv]
// Q16.16 multiplier, 48 x 33 signed, floor shift by 16, 48-bit saturation.
// Four register stages; depends on perbg_pkg.
module perbg_mulq (
   input  logic                               clock,
   input  logic                               en,
   input  logic signed [perbg_pkg::WIDE_W-1:0]  a_i,
   input  logic signed [perbg_pkg::MUL_B_W-1:0] b_i,
   output logic signed [perbg_pkg::WIDE_W-1:0]  p_o,
   output logic                               sat_o
);
   import perbg_pkg::*;

   logic [WIDE_W-1:0]  ma_ff, ma_in;
   logic [MUL_B_W-1:0] mb_ff, mb_in;
   logic               neg1_ff, neg2_ff, neg3_ff;
   logic [48:0]        pp0_ff, pp1_ff, pp2_ff;
   logic [48:0]        pp0_in, pp1_in, pp2_in;
   logic [80:0]        sum_in;
   logic [64:0]        mag_ff, mag_in;
   logic               rem_ff, rem_in;
   logic [64:0]        mag_r;
   logic signed [WIDE_W-1:0] p_ff, p_in;
   logic               sat_ff, sat_in;

   always_comb begin
      ma_in  = a_i[WIDE_W-1] ? WIDE_W'(-a_i) : WIDE_W'(a_i);
      mb_in  = b_i[MUL_B_W-1] ? MUL_B_W'(-b_i) : MUL_B_W'(b_i);
      pp0_in = 49'(ma_ff[15:0]) * 49'(mb_ff);
      pp1_in = 49'(ma_ff[31:16]) * 49'(mb_ff);
      pp2_in = 49'(ma_ff[47:32]) * 49'(mb_ff);
      sum_in = 81'(pp0_ff) + (81'(pp1_ff) << 16) + (81'(pp2_ff) << 32);
      mag_in = sum_in[80:16];
      rem_in = |sum_in[15:0];
      // negative side rounds toward minus infinity
      mag_r  = mag_ff + 65'(rem_ff);
      if (!neg3_ff) begin
         sat_in = mag_ff > 65'h7FFF_FFFF_FFFF;
         p_in   = sat_in ? W48_HI[WIDE_W-1:0] : mag_ff[WIDE_W-1:0];
      end else begin
         sat_in = mag_r > 65'h8000_0000_0000;
         p_in   = sat_in ? W48_LO[WIDE_W-1:0] : WIDE_W'(48'd0 - mag_r[WIDE_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ma_ff   <= ma_in;
         mb_ff   <= mb_in;
         neg1_ff <= a_i[WIDE_W-1] ^ b_i[MUL_B_W-1];
         pp0_ff  <= pp0_in;
         pp1_ff  <= pp1_in;
         pp2_ff  <= pp2_in;
         neg2_ff <= neg1_ff;
         mag_ff  <= mag_in;
         rem_ff  <= rem_in;
         neg3_ff <= neg2_ff;
         p_ff    <= p_in;
         sat_ff  <= sat_in;
      end
   end

   assign p_o   = p_ff;
   assign sat_o = sat_ff;

endmodule

[rtl/core/perbg_fifo.sv]
// Small register queue between front and back.
// Depends on nothing but its parameters.
module perbg_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_pop,
   output logic [WIDTH-1:0] out_data
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             push, pop;

   always_comb begin
      in_ready  = count_ff != CW'(DEPTH);
      out_valid = count_ff != '0;
      push      = in_valid && in_ready;
      pop       = out_pop && out_valid;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      count_in = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

   assign out_data = slot_ff[rd_ptr_ff];

endmodule

[rtl/core/perbg_front.sv]
// Front end: takes request beats, wraps coordinates into the grid, packs the item.
// Depends on perbg_pkg.
module perbg_front #(
   parameter int DIM_X = perbg_pkg::DIM_X_DEF,
   parameter int DIM_Y = perbg_pkg::DIM_Y_DEF,
   parameter int DIM_Z = perbg_pkg::DIM_Z_DEF,
   localparam int ITEM_W = perbg_pkg::item_w(DIM_X, DIM_Y, DIM_Z)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_type,
   input  logic [perbg_pkg::POS_W-1:0]       req_pos_x,
   input  logic [perbg_pkg::POS_W-1:0]       req_pos_y,
   input  logic [perbg_pkg::POS_W-1:0]       req_pos_z,
   input  logic signed [perbg_pkg::DATA_W-1:0] req_cell_value,
   input  logic signed [perbg_pkg::DATA_W-1:0] req_vel_x,
   input  logic signed [perbg_pkg::DATA_W-1:0] req_vel_y,
   input  logic signed [perbg_pkg::DATA_W-1:0] req_vel_z,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [ITEM_W-1:0]                 out_data
);
   import perbg_pkg::*;

   localparam int XW = $clog2(DIM_X);
   localparam int YW = $clog2(DIM_Y);
   localparam int ZW = $clog2(DIM_Z);

   logic [XW-1:0] xtab [POS_VALUES];
   logic [YW-1:0] ytab [POS_VALUES];
   logic [ZW-1:0] ztab [POS_VALUES];

   logic              valid_ff, valid_in;
   logic [ITEM_W-1:0] item_ff, item_in;
   logic              accept;

   // coordinate modulo dimension, one constant table per axis
   for (genvar i = 0; i < POS_VALUES; i++) begin : g_wrap
      assign xtab[i] = XW'(i % DIM_X);
      assign ytab[i] = YW'(i % DIM_Y);
      assign ztab[i] = ZW'(i % DIM_Z);
   end

   always_comb begin
      req_ready = !valid_ff || out_ready;
      accept    = req_valid && req_ready;
      item_in   = {req_type, xtab[req_pos_x], ytab[req_pos_y], ztab[req_pos_z],
                   req_cell_value, req_vel_x, req_vel_y, req_vel_z};
      valid_in  = accept || (valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = item_ff;

endmodule

[rtl/core/perbg_back.sv]
// Back end: grid memory, neighbor read sequencer and the Q16.16 stencil pipeline.
// Depends on perbg_pkg and perbg_mulq.
module perbg_back #(
   parameter int DIM_X = perbg_pkg::DIM_X_DEF,
   parameter int DIM_Y = perbg_pkg::DIM_Y_DEF,
   parameter int DIM_Z = perbg_pkg::DIM_Z_DEF,
   localparam int ITEM_W = perbg_pkg::item_w(DIM_X, DIM_Y, DIM_Z)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  perbg_pkg::coef_type               coef,
   input  logic                              head_valid,
   input  logic [ITEM_W-1:0]                 head_data,
   output logic                              head_pop,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [perbg_pkg::POS_W-1:0]       rsp_out_x,
   output logic [perbg_pkg::POS_W-1:0]       rsp_out_y,
   output logic [perbg_pkg::POS_W-1:0]       rsp_out_z,
   output logic signed [perbg_pkg::DATA_W-1:0] rsp_new_value,
   output logic                              rsp_saturated
);
   import perbg_pkg::*;

   localparam int XW      = $clog2(DIM_X);
   localparam int YW      = $clog2(DIM_Y);
   localparam int ZW      = $clog2(DIM_Z);
   localparam int CELLS   = DIM_X * DIM_Y * DIM_Z;
   localparam int AW      = $clog2(CELLS);
   localparam int VZ_LSB  = 0;
   localparam int VY_LSB  = DATA_W;
   localparam int VX_LSB  = 2 * DATA_W;
   localparam int VAL_LSB = 3 * DATA_W;
   localparam int Z_LSB   = 4 * DATA_W;
   localparam int Y_LSB   = Z_LSB + ZW;
   localparam int X_LSB   = Y_LSB + YW;
   localparam int K_BIT   = X_LSB + XW;
   localparam logic [AW-1:0] DY_A = AW'(DIM_Y);
   localparam logic [AW-1:0] DZ_A = AW'(DIM_Z);

   // ---------------- gather ----------------
   logic [DATA_W-1:0] mem [CELLS];
   logic [DATA_W-1:0] rd_data_ff;
   logic              adv, take, is_upd, wr_en, rd_en;
   logic              active_ff, active_in;
   nb_slot_type       slot_ff, slot_in, slot_sel;
   logic [XW-1:0]     bx, ax, xm, xp, h_x, cur_x_ff;
   logic [YW-1:0]     by, ay, ym, yp, h_y, cur_y_ff;
   logic [ZW-1:0]     bz, az, zm, zp, h_z, cur_z_ff;
   logic [AW-1:0]     addr;
   logic [DATA_W-1:0] cur_u_ff, cur_vx_ff, cur_vy_ff, cur_vz_ff;
   logic              tag_valid_ff;
   nb_slot_type       tag_slot_ff;
   logic [DATA_W-1:0] nb_ff [5];

   // ---------------- launch ----------------
   logic              l_valid_ff;
   logic [POS_W-1:0]  l_x_ff, l_y_ff, l_z_ff;
   logic signed [DATA_W-1:0] l_u_ff, l_vx_ff, l_vy_ff, l_vz_ff;
   logic signed [DATA_W-1:0] l_xm_ff, l_xp_ff, l_ym_ff, l_yp_ff, l_zm_ff, l_zp_ff;

   // ---------------- arithmetic ----------------
   carry_type         g1_ff [MUL_LAT];
   carry_type         g2_ff [MUL_LAT];
   carry_type         g3_ff [MUL_LAT];
   carry_type         g1_in, a_carry_ff, a_carry_in, b_carry_ff, b_carry_in;
   logic signed [WIDE_W-1:0] a_s_ff, a_d_ff, b_inner_ff;
   clamp48_type       cl_s, cl_d, cl_i;
   clamp32_type       cl_r;
   logic signed [WIDE_W-1:0] p_s, p_c, p_px, p_py, p_pz, p_a, p_e, p_f;
   logic              sat_s, sat_c, sat_px, sat_py, sat_pz, sat_a, sat_e, sat_f;
   logic signed [WIDE_W-1:0] c2x3;

   logic              rsp_valid_ff;
   logic [POS_W-1:0]  rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic [DATA_W-1:0] rsp_val_ff;
   logic              rsp_sat_ff;

   // whole back end moves together; the result register is the only stall point
   assign adv = !rsp_valid_ff || rsp_ready;

   assign h_x = head_data[X_LSB +: XW];
   assign h_y = head_data[Y_LSB +: YW];
   assign h_z = head_data[Z_LSB +: ZW];

   always_comb begin
      is_upd   = head_data[K_BIT] == KIND_UPDATE;
      take     = adv && !active_ff && head_valid;
      wr_en    = take && !is_upd;
      rd_en    = adv && (active_ff || (head_valid && is_upd));
      slot_sel = active_ff ? slot_ff : NB_XM;
      bx = active_ff ? cur_x_ff : h_x;
      by = active_ff ? cur_y_ff : h_y;
      bz = active_ff ? cur_z_ff : h_z;
      xm = (bx == '0) ? XW'(DIM_X - 1) : bx - XW'(1);
      xp = (bx == XW'(DIM_X - 1)) ? '0 : bx + XW'(1);
      ym = (by == '0) ? YW'(DIM_Y - 1) : by - YW'(1);
      yp = (by == YW'(DIM_Y - 1)) ? '0 : by + YW'(1);
      zm = (bz == '0) ? ZW'(DIM_Z - 1) : bz - ZW'(1);
      zp = (bz == ZW'(DIM_Z - 1)) ? '0 : bz + ZW'(1);
      ax = bx;
      ay = by;
      az = bz;
      if (rd_en) begin
         case (slot_sel)
            NB_XM: ax = xm;
            NB_XP: ax = xp;
            NB_YM: ay = ym;
            NB_YP: ay = yp;
            NB_ZM: az = zm;
            NB_ZP: az = zp;
            default: ;
         endcase
      end
      addr = (AW'(ax) * DY_A + AW'(ay)) * DZ_A + AW'(az);

      active_in = active_ff;
      slot_in   = slot_ff;
      if (adv) begin
         if (active_ff) begin
            if (slot_ff == NB_ZP) begin
               active_in = 1'b0;
            end else begin
               slot_in = nb_slot_type'(slot_ff + 3'd1);
            end
         end else if (take && is_upd) begin
            active_in = 1'b1;
            slot_in   = NB_XP;
         end
      end
   end

   assign head_pop = take;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= head_data[VAL_LSB +: DATA_W];
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   // ---------------- arithmetic comb ----------------
   always_comb begin
      c2x3 = WIDE_W'($signed(coef.center)) + (WIDE_W'($signed(coef.center)) <<< 1);

      g1_in       = '0;
      g1_in.valid = l_valid_ff;
      g1_in.x     = l_x_ff;
      g1_in.y     = l_y_ff;
      g1_in.z     = l_z_ff;
      g1_in.u     = l_u_ff;
      g1_in.nsum  = NSUM_W'(l_xp_ff) + NSUM_W'(l_ym_ff) + NSUM_W'(l_yp_ff)
                  + NSUM_W'(l_zm_ff) + NSUM_W'(l_zp_ff);

      cl_s = clamp48(SUM_W'(p_s) + SUM_W'($signed(g1_ff[MUL_LAT-1].nsum)));
      cl_d = clamp48(SUM_W'(p_px) + SUM_W'(p_py) + SUM_W'(p_pz));
      a_carry_in       = g1_ff[MUL_LAT-1];
      a_carry_in.cterm = p_c;
      a_carry_in.sat   = sat_s | sat_c | sat_px | sat_py | sat_pz | cl_s.sat | cl_d.sat;

      cl_i = clamp48(SUM_W'(p_a) - SUM_W'($signed(g2_ff[MUL_LAT-1].cterm)) - SUM_W'(p_e));
      b_carry_in     = g2_ff[MUL_LAT-1];
      b_carry_in.sat = g2_ff[MUL_LAT-1].sat | sat_a | sat_e | cl_i.sat;

      cl_r = clamp32(49'($signed(g3_ff[MUL_LAT-1].u)) + 49'(p_f));
   end

   perbg_mulq u_mul_s (
      .clock(clock), .en(adv),
      .a_i(WIDE_W'($signed(coef.first))), .b_i(MUL_B_W'(l_xm_ff)),
      .p_o(p_s), .sat_o(sat_s)
   );
   perbg_mulq u_mul_c (
      .clock(clock), .en(adv),
      .a_i(c2x3), .b_i(MUL_B_W'(l_u_ff)),
      .p_o(p_c), .sat_o(sat_c)
   );
   perbg_mulq u_mul_px (
      .clock(clock), .en(adv),
      .a_i(WIDE_W'(l_vx_ff)), .b_i(MUL_B_W'(l_xp_ff) - MUL_B_W'(l_xm_ff)),
      .p_o(p_px), .sat_o(sat_px)
   );
   perbg_mulq u_mul_py (
      .clock(clock), .en(adv),
      .a_i(WIDE_W'(l_vy_ff)), .b_i(MUL_B_W'(l_yp_ff) - MUL_B_W'(l_ym_ff)),
      .p_o(p_py), .sat_o(sat_py)
   );
   perbg_mulq u_mul_pz (
      .clock(clock), .en(adv),
      .a_i(WIDE_W'(l_vz_ff)), .b_i(MUL_B_W'(l_zp_ff) - MUL_B_W'(l_zm_ff)),
      .p_o(p_pz), .sat_o(sat_pz)
   );
   perbg_mulq u_mul_a (
      .clock(clock), .en(adv),
      .a_i(a_s_ff), .b_i(MUL_B_W'($signed(coef.diffuse))),
      .p_o(p_a), .sat_o(sat_a)
   );
   perbg_mulq u_mul_e (
      .clock(clock), .en(adv),
      .a_i(a_d_ff), .b_i(MUL_B_W'($signed(coef.advect))),
      .p_o(p_e), .sat_o(sat_e)
   );
   perbg_mulq u_mul_f (
      .clock(clock), .en(adv),
      .a_i(b_inner_ff), .b_i(MUL_B_W'($signed(coef.step))),
      .p_o(p_f), .sat_o(sat_f)
   );

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         slot_ff      <= NB_XM;
         tag_valid_ff <= 1'b0;
         l_valid_ff   <= 1'b0;
         a_carry_ff   <= '0;
         b_carry_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MUL_LAT; i++) begin
            g1_ff[i] <= '0;
            g2_ff[i] <= '0;
            g3_ff[i] <= '0;
         end
      end else begin
         active_ff <= active_in;
         slot_ff   <= slot_in;
         if (adv) begin
            tag_valid_ff <= rd_en;
            l_valid_ff   <= tag_valid_ff && (tag_slot_ff == NB_ZP);
            g1_ff[0]     <= g1_in;
            g2_ff[0]     <= a_carry_ff;
            g3_ff[0]     <= b_carry_ff;
            for (int i = 1; i < MUL_LAT; i++) begin
               g1_ff[i] <= g1_ff[i-1];
               g2_ff[i] <= g2_ff[i-1];
               g3_ff[i] <= g3_ff[i-1];
            end
            a_carry_ff   <= a_carry_in;
            b_carry_ff   <= b_carry_in;
            rsp_valid_ff <= g3_ff[MUL_LAT-1].valid;
         end
      end
   end

   // ---------------- payload registers ----------------
   always_ff @(posedge clock) begin
      if (take && is_upd) begin
         cur_x_ff  <= h_x;
         cur_y_ff  <= h_y;
         cur_z_ff  <= h_z;
         cur_u_ff  <= head_data[VAL_LSB +: DATA_W];
         cur_vx_ff <= head_data[VX_LSB +: DATA_W];
         cur_vy_ff <= head_data[VY_LSB +: DATA_W];
         cur_vz_ff <= head_data[VZ_LSB +: DATA_W];
      end
      if (adv) begin
         tag_slot_ff <= slot_sel;
         if (tag_valid_ff && (tag_slot_ff != NB_ZP)) begin
            nb_ff[tag_slot_ff] <= rd_data_ff;
         end
         l_x_ff  <= POS_W'(cur_x_ff);
         l_y_ff  <= POS_W'(cur_y_ff);
         l_z_ff  <= POS_W'(cur_z_ff);
         l_u_ff  <= cur_u_ff;
         l_vx_ff <= cur_vx_ff;
         l_vy_ff <= cur_vy_ff;
         l_vz_ff <= cur_vz_ff;
         l_xm_ff <= nb_ff[NB_XM];
         l_xp_ff <= nb_ff[NB_XP];
         l_ym_ff <= nb_ff[NB_YM];
         l_yp_ff <= nb_ff[NB_YP];
         l_zm_ff <= nb_ff[NB_ZM];
         l_zp_ff <= rd_data_ff;
         a_s_ff     <= cl_s.val;
         a_d_ff     <= cl_d.val;
         b_inner_ff <= cl_i.val;
         rsp_x_ff   <= g3_ff[MUL_LAT-1].x;
         rsp_y_ff   <= g3_ff[MUL_LAT-1].y;
         rsp_z_ff   <= g3_ff[MUL_LAT-1].z;
         rsp_val_ff <= cl_r.val;
         rsp_sat_ff <= g3_ff[MUL_LAT-1].sat | sat_f | cl_r.sat;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_x     = rsp_x_ff;
   assign rsp_out_y     = rsp_y_ff;
   assign rsp_out_z     = rsp_z_ff;
   assign rsp_new_value = rsp_val_ff;
   assign rsp_saturated = rsp_sat_ff;

endmodule

[rtl/core/periodic_burgers_stencil_3d_top.sv]
// Top level of the periodic 3D Burgers stencil: coefficient registers, front, queue, back.
// Depends on perbg_pkg, perbg_front, perbg_fifo, perbg_back.
//
//   channel | dir | handshake            | beat
//   req_    | in  | req_valid/req_ready  | load v cell or update u cell
//   rsp_    | out | rsp_valid/rsp_ready  | updated cell with saturation flag
//   csr_    | in  | csr_wr_en            | coefficient write, no wait
//
// An update holds the back end for one read per neighbor on the single port of the grid
// memory; a load holds it for its write alone. The path from queue head to rsp_valid runs
// through the neighbor reads, the launch registers and three 4-stage multiplier groups.
// Reset clears control state and coefficients; the grid memory is not cleared and
// needs no clearing pass. A stalled rsp_ channel freezes the whole back end; the
// front and the queue keep taking beats until the queue fills.
module periodic_burgers_stencil_3d_top #(
   parameter int DIM_X       = perbg_pkg::DIM_X_DEF,
   parameter int DIM_Y       = perbg_pkg::DIM_Y_DEF,
   parameter int DIM_Z       = perbg_pkg::DIM_Z_DEF,
   parameter int QUEUE_DEPTH = perbg_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_type,
   input  logic [perbg_pkg::POS_W-1:0]         req_pos_x,
   input  logic [perbg_pkg::POS_W-1:0]         req_pos_y,
   input  logic [perbg_pkg::POS_W-1:0]         req_pos_z,
   input  logic signed [perbg_pkg::DATA_W-1:0] req_cell_value,
   input  logic signed [perbg_pkg::DATA_W-1:0] req_vel_x,
   input  logic signed [perbg_pkg::DATA_W-1:0] req_vel_y,
   input  logic signed [perbg_pkg::DATA_W-1:0] req_vel_z,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [perbg_pkg::POS_W-1:0]         rsp_out_x,
   output logic [perbg_pkg::POS_W-1:0]         rsp_out_y,
   output logic [perbg_pkg::POS_W-1:0]         rsp_out_z,
   output logic signed [perbg_pkg::DATA_W-1:0] rsp_new_value,
   output logic                                rsp_saturated,
   input  logic                                csr_wr_en,
   input  logic [perbg_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [perbg_pkg::DATA_W-1:0]        csr_wdata
);
   import perbg_pkg::*;

   localparam int ITEM_W = item_w(DIM_X, DIM_Y, DIM_Z);

   coef_type          coef_ff, coef_in;
   logic              f_valid, f_ready;
   logic [ITEM_W-1:0] f_data;
   logic              q_valid, q_pop;
   logic [ITEM_W-1:0] q_data;

   // coefficient file; indexes past the last register fall through
   always_comb begin
      coef_in = coef_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_ADVECT:  coef_in.advect  = csr_wdata;
            CSR_FIRST:   coef_in.first   = csr_wdata;
            CSR_CENTER:  coef_in.center  = csr_wdata;
            CSR_DIFFUSE: coef_in.diffuse = csr_wdata;
            CSR_STEP:    coef_in.step    = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else begin
         coef_ff <= coef_in;
      end
   end

   // front: coordinate wrap and packing
   perbg_front #(
      .DIM_X(DIM_X), .DIM_Y(DIM_Y), .DIM_Z(DIM_Z)
   ) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y), .req_pos_z(req_pos_z),
      .req_cell_value(req_cell_value),
      .req_vel_x(req_vel_x), .req_vel_y(req_vel_y), .req_vel_z(req_vel_z),
      .out_valid(f_valid), .out_ready(f_ready), .out_data(f_data)
   );

   // decoupling queue
   perbg_fifo #(
      .WIDTH(ITEM_W), .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
      .out_valid(q_valid), .out_pop(q_pop), .out_data(q_data)
   );

   // back: grid memory, neighbor sequencer, arithmetic pipeline, result register
   perbg_back #(
      .DIM_X(DIM_X), .DIM_Y(DIM_Y), .DIM_Z(DIM_Z)
   ) u_back (
      .clock(clock), .reset(reset), .coef(coef_ff),
      .head_valid(q_valid), .head_data(q_data), .head_pop(q_pop),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_out_x(rsp_out_x), .rsp_out_y(rsp_out_y), .rsp_out_z(rsp_out_z),
      .rsp_new_value(rsp_new_value), .rsp_saturated(rsp_saturated)
   );

endmodule

[dv/perbg_stencil_checker.sv]
// Result checker for the periodic 3D Burgers stencil: tracks coefficients and the v grid,
// predicts each update beat and compares every response field. Depends on perbg_pkg.
module perbg_stencil_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic                                req_type,
   input  logic [perbg_pkg::POS_W-1:0]         req_pos_x,
   input  logic [perbg_pkg::POS_W-1:0]         req_pos_y,
   input  logic [perbg_pkg::POS_W-1:0]         req_pos_z,
   input  logic signed [perbg_pkg::DATA_W-1:0] req_cell_value,
   input  logic signed [perbg_pkg::DATA_W-1:0] req_vel_x,
   input  logic signed [perbg_pkg::DATA_W-1:0] req_vel_y,
   input  logic signed [perbg_pkg::DATA_W-1:0] req_vel_z,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [perbg_pkg::POS_W-1:0]         rsp_out_x,
   input  logic [perbg_pkg::POS_W-1:0]         rsp_out_y,
   input  logic [perbg_pkg::POS_W-1:0]         rsp_out_z,
   input  logic signed [perbg_pkg::DATA_W-1:0] rsp_new_value,
   input  logic                                rsp_saturated,
   input  logic                                csr_wr_en,
   input  logic [perbg_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [perbg_pkg::DATA_W-1:0]        csr_wdata,
   output int                                  updates_in_flight,
   output int                                  mismatch_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import perbg_pkg::*;

   localparam int CELL_COUNT = DIM_X_DEF * DIM_Y_DEF * DIM_Z_DEF;

   typedef logic signed [127:0] wide_type;

   typedef struct {
      logic [POS_W-1:0]  x;
      logic [POS_W-1:0]  y;
      logic [POS_W-1:0]  z;
      logic [DATA_W-1:0] value;
      logic              sat;
   } cell_update_type;

   logic [DATA_W-1:0] v_grid [0:CELL_COUNT-1];
   coef_type          coefs;
   cell_update_type   predicted_updates [$];

   assign updates_in_flight = predicted_updates.size();

   function automatic int cell_addr(input int x, input int y, input int z);
      return (x * DIM_Y_DEF + y) * DIM_Z_DEF + z;
   endfunction

   function automatic wide_type v_at(input int x, input int y, input int z);
      wide_type r;
      r = $signed(v_grid[cell_addr(x, y, z)]);
      return r;
   endfunction

   function automatic wide_type clip(input wide_type v, input int bits, inout logic sat);
      wide_type hi, lo;
      hi = (wide_type'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
         sat = 1'b1;
         return hi;
      end
      if (v < lo) begin
         sat = 1'b1;
         return lo;
      end
      return v;
   endfunction

   // Q16.16 product, floor shift, held to 48 bits
   function automatic wide_type qmul(input wide_type a, input wide_type b, inout logic sat);
      wide_type p;
      p = (a * b) >>> 16;
      return clip(p, WIDE_W, sat);
   endfunction

   function automatic cell_update_type stencil_step(input int x, input int y, input int z,
                                                    input wide_type u, input wide_type ux,
                                                    input wide_type uy, input wide_type uz);
      cell_update_type r;
      logic     sat;
      int       xm, xp, ym, yp, zm, zp;
      wide_type vxm, vxp, vym, vyp, vzm, vzp, nsum, diffuse, center, px, py, pz;
      wide_type adv, advect, inner, dt;
      sat = 1'b0;
      xm = (x + DIM_X_DEF - 1) % DIM_X_DEF;  xp = (x + 1) % DIM_X_DEF;
      ym = (y + DIM_Y_DEF - 1) % DIM_Y_DEF;  yp = (y + 1) % DIM_Y_DEF;
      zm = (z + DIM_Z_DEF - 1) % DIM_Z_DEF;  zp = (z + 1) % DIM_Z_DEF;
      vxm = v_at(xm, y, z);  vxp = v_at(xp, y, z);
      vym = v_at(x, ym, z);  vyp = v_at(x, yp, z);
      vzm = v_at(x, y, zm);  vzp = v_at(x, y, zp);
      // only the x-minus neighbor carries c1
      nsum = qmul($signed(coefs.first), vxm, sat);
      nsum = clip(nsum + vxp + vym + vyp + vzm + vzp, WIDE_W, sat);
      diffuse = qmul(nsum, $signed(coefs.diffuse), sat);
      center = qmul(wide_type'($signed(coefs.center)) * 3, u, sat);
      px = qmul(ux, vxp - vxm, sat);
      py = qmul(uy, vyp - vym, sat);
      pz = qmul(uz, vzp - vzm, sat);
      adv = clip(px + py + pz, WIDE_W, sat);
      advect = qmul(adv, $signed(coefs.advect), sat);
      inner = clip(diffuse - center - advect, WIDE_W, sat);
      dt = qmul(inner, $signed(coefs.step), sat);
      dt = clip(u + dt, DATA_W, sat);
      r.x = POS_W'(x);
      r.y = POS_W'(y);
      r.z = POS_W'(z);
      r.value = dt[DATA_W-1:0];
      r.sat = sat;
      return r;
   endfunction

   always @(posedge clock) begin
      cell_update_type want;
      if (reset) begin
         coefs <= '0;
         predicted_updates.delete();
         mismatch_count <= 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_ADVECT:  coefs.advect  <= csr_wdata;
               CSR_FIRST:   coefs.first   <= csr_wdata;
               CSR_CENTER:  coefs.center  <= csr_wdata;
               CSR_DIFFUSE: coefs.diffuse <= csr_wdata;
               CSR_STEP:    coefs.step    <= csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (req_kind_type'(req_type) == KIND_LOAD) begin
               v_grid[cell_addr(req_pos_x % DIM_X_DEF, req_pos_y % DIM_Y_DEF,
                                req_pos_z % DIM_Z_DEF)] = req_cell_value;
            end else begin
               predicted_updates.push_back(stencil_step(
                  req_pos_x % DIM_X_DEF, req_pos_y % DIM_Y_DEF, req_pos_z % DIM_Z_DEF,
                  req_cell_value, req_vel_x, req_vel_y, req_vel_z));
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (predicted_updates.size() == 0) begin
               if (mismatch_count < 10)
                  $display("%0t: response beat with no update outstanding", $realtime);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = predicted_updates.pop_front();
               if (rsp_out_x !== want.x || rsp_out_y !== want.y || rsp_out_z !== want.z ||
                   rsp_new_value !== want.value || rsp_saturated !== want.sat) begin
                  if (mismatch_count < 10)
                     $display({"%0t: cell mismatch: want (%0d,%0d,%0d) %h sat %b, ",
                               "got (%0d,%0d,%0d) %h sat %b"},
                              $realtime, want.x, want.y, want.z, want.value, want.sat,
                              rsp_out_x, rsp_out_y, rsp_out_z, rsp_new_value,
                              rsp_saturated);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
      end
   end

endmodule

[dv/testbench.sv]
// Top of the stencil testbench: clock, reset, coefficient phases, load/update stimulus
// and response back-pressure. Depends on perbg_pkg, the block and perbg_stencil_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import perbg_pkg::*;

   localparam int CELL_COUNT  = DIM_X_DEF * DIM_Y_DEF * DIM_Z_DEF;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE      = 40;    // longer than the pipe plus a load slot
   localparam int PHASE_BEATS = 215;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_type = 1'b0;
   logic [POS_W-1:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic signed [DATA_W-1:0] req_cell_value = '0, req_vel_x = '0, req_vel_y = '0;
   logic signed [DATA_W-1:0] req_vel_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [POS_W-1:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic signed [DATA_W-1:0] rsp_new_value;
   logic rsp_saturated;
   logic csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [DATA_W-1:0] csr_wdata = '0;

   int updates_in_flight;
   int mismatch_count;
   int cycle_count = 0;
   int beats_sent = 0;
   bit no_idle = 1'b0;      // phases with back-to-back beats
   bit hold_off = 1'b0;     // asks the receiver for one long stall
   bit loaded [0:CELL_COUNT-1];

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   periodic_burgers_stencil_3d_top i_dut (.*);

   perbg_stencil_checker i_checker (.*);

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // mostly short gaps, some long ones
   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Q16.16 operand: small values dominate so results rarely clip, extremes still show up
   function automatic logic [DATA_W-1:0] pick_q();
      int r;
      logic [DATA_W-1:0] v;
      r = $urandom_range(0, 99);
      if (r < 45) begin
         v = $urandom_range(0, 32'h3FFFF);
         if ($urandom_range(0, 1)) v = -v;
      end else if (r < 75) begin
         v = $urandom();
      end else if (r < 90) begin
         case ($urandom_range(0, 3))
            0: v = 32'h7FFF_FFFF;
            1: v = 32'h8000_0000;
            2: v = 32'h0000_0000;
            default: v = 32'hFFFF_FFFF;
         endcase
      end else begin
         v = $urandom_range(0, 32'h7FF_FFFF);
         if ($urandom_range(0, 1)) v = -v;
      end
      return v;
   endfunction

   // half the cells land near the wrap boundaries
   function automatic logic [POS_W-1:0] pick_pos();
      logic [POS_W-1:0] edges [6];
      edges = '{5'd0, 5'd1, 5'd2, 5'd29, 5'd30, 5'd31};
      if ($urandom_range(0, 1)) return edges[$urandom_range(0, 5)];
      return POS_W'($urandom());
   endfunction

   function automatic int addr_of(input int x, input int y, input int z);
      return (x * DIM_Y_DEF + y) * DIM_Z_DEF + z;
   endfunction

   // Valid stays high between beats unless a gap is taken.
   task automatic send_beat(input req_kind_type kind, input logic [POS_W-1:0] x,
                            input logic [POS_W-1:0] y, input logic [POS_W-1:0] z,
                            input logic [DATA_W-1:0] val, input logic [DATA_W-1:0] ux,
                            input logic [DATA_W-1:0] uy, input logic [DATA_W-1:0] uz);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_pos_x <= x;
      req_pos_y <= y;
      req_pos_z <= z;
      req_cell_value <= val;
      req_vel_x <= ux;
      req_vel_y <= uy;
      req_vel_z <= uz;
      do @(posedge clock); while (!req_ready);
      if (kind == KIND_LOAD) loaded[addr_of(x, y, z)] = 1'b1;
      beats_sent++;
   endtask

   task automatic load_cell(input int x, input int y, input int z, input logic [DATA_W-1:0] v);
      send_beat(KIND_LOAD, POS_W'(x), POS_W'(y), POS_W'(z), v, $urandom(), $urandom(),
                $urandom());
   endtask

   // Loads the six wrapped neighbors (fresh ones always, known ones sometimes), then updates.
   // extreme_v forces full-scale neighbor values.
   task automatic stencil_burst(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                                input logic [POS_W-1:0] z, input bit extreme_v,
                                input logic [DATA_W-1:0] u, input logic [DATA_W-1:0] ux,
                                input logic [DATA_W-1:0] uy, input logic [DATA_W-1:0] uz);
      int nb [6][3];
      logic [DATA_W-1:0] v;
      nb[0] = '{(x + 31) % 32, y, z};  nb[1] = '{(x + 1) % 32, y, z};
      nb[2] = '{x, (y + 31) % 32, z};  nb[3] = '{x, (y + 1) % 32, z};
      nb[4] = '{x, y, (z + 31) % 32};  nb[5] = '{x, y, (z + 1) % 32};
      for (int i = 0; i < 6; i++) begin
         if (extreme_v || !loaded[addr_of(nb[i][0], nb[i][1], nb[i][2])] ||
             $urandom_range(0, 99) < 30) begin
            if (extreme_v) v = (i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
            else v = pick_q();
            load_cell(nb[i][0], nb[i][1], nb[i][2], v);
         end
      end
      send_beat(KIND_UPDATE, x, y, z, u, ux, uy, uz);
   endtask

   task automatic write_coef(input logic [CSR_INDEX_W-1:0] idx, input logic [DATA_W-1:0] v);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_coefs(input logic [DATA_W-1:0] c0, input logic [DATA_W-1:0] c1,
                            input logic [DATA_W-1:0] c2, input logic [DATA_W-1:0] c3,
                            input logic [DATA_W-1:0] c4);
      write_coef(CSR_ADVECT, c0);
      write_coef(CSR_FIRST, c1);
      write_coef(CSR_CENTER, c2);
      write_coef(CSR_DIFFUSE, c3);
      write_coef(CSR_STEP, c4);
   endtask

   // Results done, then room for a trailing load still in the back end.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (updates_in_flight != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Random section: mostly well-formed neighbor-load-then-update bursts, some stray loads
   // and some updates of cells whose neighbors happen to be known already.
   task automatic random_phase(input int beats);
      int stop, r, reps;
      logic [POS_W-1:0] x, y, z;
      stop = beats_sent + beats;
      while (beats_sent < stop) begin
         r = $urandom_range(0, 99);
         x = pick_pos();
         y = pick_pos();
         z = pick_pos();
         if (r < 85) begin
            stencil_burst(x, y, z, 1'b0, pick_q(), pick_q(), pick_q(), pick_q());
            reps = $urandom_range(0, 2);
            repeat (reps) send_beat(KIND_UPDATE, x, y, z, pick_q(), pick_q(), pick_q(),
                                    pick_q());
         end else if (r < 95) begin
            send_beat(KIND_LOAD, x, y, z, pick_q(), $urandom(), $urandom(), $urandom());
         end else if (loaded[addr_of((x + 31) % 32, y, z)] &&
                      loaded[addr_of((x + 1) % 32, y, z)] &&
                      loaded[addr_of(x, (y + 31) % 32, z)] &&
                      loaded[addr_of(x, (y + 1) % 32, z)] &&
                      loaded[addr_of(x, y, (z + 31) % 32)] &&
                      loaded[addr_of(x, y, (z + 1) % 32)]) begin
            send_beat(KIND_UPDATE, x, y, z, pick_q(), pick_q(), pick_q(), pick_q());
         end
      end
   endtask

   function automatic logic [DATA_W-1:0] pick_coef();
      logic [DATA_W-1:0] v;
      v = $urandom_range(0, 32'h3FFFF);
      if ($urandom_range(0, 1)) v = -v;
      return v;
   endfunction

   // Receiver: random stalls, plus one long hold-off when asked so the queue backs up.
   initial begin
      int n;
      @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_ready <= 1'b0;
            repeat (300) @(negedge clock);
            hold_off = 1'b0;
         end else begin
            n = pick_gap();
            if (n == 0) begin
               rsp_ready <= 1'b1;
               @(negedge clock);
            end else begin
               rsp_ready <= 1'b0;
               repeat (n) @(negedge clock);
            end
         end
      end
   end

   initial begin
      foreach (loaded[i]) loaded[i] = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: unit-ish coefficients, corner cells, extreme operands
      set_coefs(32'h0000_8000, 32'h0001_0000, 32'h0000_4000, 32'h0000_2000, 32'h0000_1999);
      write_coef(CSR_UNUSED, 32'hDEAD_BEEF);   // ignored index
      stencil_burst(5'd0, 5'd0, 5'd0, 1'b0, 32'h0001_0000, 32'h0000_8000, 32'hFFFF_8000,
                    32'h0000_0000);
      stencil_burst(5'd31, 5'd31, 5'd31, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h7FFF_FFFF);
      stencil_burst(5'd0, 5'd31, 5'd0, 1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h8000_0000);
      send_beat(KIND_UPDATE, 5'd0, 5'd0, 5'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF);
      drain();

      // full-scale coefficients: heavy clipping
      set_coefs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      stencil_burst(5'd31, 5'd0, 5'd31, 1'b1, 32'h7FFF_FFFF, 32'h0001_0000, 32'h0001_0000,
                    32'h0001_0000);
      random_phase(60);
      drain();

      // modest coefficients, with one long response hold-off while requests keep coming
      set_coefs(pick_coef(), pick_coef(), pick_coef(), pick_coef(), pick_coef());
      hold_off = 1'b1;
      random_phase(PHASE_BEATS);
      drain();

      // back-to-back beats, the other extremes
      no_idle = 1'b1;
      set_coefs(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      random_phase(PHASE_BEATS / 2);
      drain();
      no_idle = 1'b0;

      // fully random coefficients
      set_coefs($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      random_phase(PHASE_BEATS);
      drain();

      // zero coefficients pass u through
      set_coefs('0, '0, '0, '0, '0);
      random_phase(PHASE_BEATS / 2);
      drain();

      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
